// ===== hdl/lmfs_pkg.sv =====
// Package for the LED matrix frame scan block.
// Holds shared constants, payload structs, command and state types.
// Depends on nothing; lmfs_front, lmfs_back and the top level import it.
package lmfs_pkg;

    // Panel geometry
    localparam int SCAN_LINES     = 16;
    localparam int WORDS_PER_LINE = 6;
    localparam int FRAME_WORDS    = SCAN_LINES * WORDS_PER_LINE;
    localparam int LINE_W         = $clog2(SCAN_LINES);
    localparam int WIDX_W         = $clog2(FRAME_WORDS);
    localparam int WCNT_W         = $clog2(WORDS_PER_LINE);
    localparam int WORD_W         = 64;
    localparam int BITPOS_W       = 6;

    // Timing constants
    localparam int WAIT_TOTAL_US  = 178;
    localparam int DUTY_FULL      = 255;
    localparam logic [7:0] BRIGHT_RESET = 8'd191;
    // floor(d * 699 / 1000) == (d * DARK_MULT) >> DARK_SHIFT for d up to 255
    localparam int DARK_SHIFT     = 28;
    localparam int DARK_MULT      = 187636764;
    localparam int DARK_PROD_W    = DARK_SHIFT + 8;

    // Queue depths
    localparam int CMDQ_DEPTH     = 4;
    localparam int CMDQ_PTR_W     = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH     = 8;
    localparam int OUTQ_PTR_W     = $clog2(OUTQ_DEPTH);

    // Input function codes
    localparam logic [1:0] FUNC_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_SCAN  = 2'd2;

    // Color plane codes
    localparam logic [1:0] COLOR_BLUE = 2'd2;

    // Result kinds
    localparam logic KIND_SHIFT = 1'b0;
    localparam logic KIND_LATCH = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] pixel_x;
        logic [4:0] pixel_y;
        logic [1:0] color;
        logic       pixel_on;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [63:0] shift_word;
        logic [3:0]  line_select;
        logic [7:0]  dark_wait_us;
        logic [7:0]  lit_wait_us;
        logic [7:0]  oe_duty;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_CLEAR,
        OP_SCAN
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [WIDX_W-1:0]   widx;
        logic [BITPOS_W-1:0] bit_pos;
        logic                pixel_on;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_PIX_WR,
        BS_SCAN,
        BS_TAIL,
        BS_LATCH
    } t_bstate;

endpackage

// ===== hdl/lmfs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the frame store.
module lmfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lmfs_front.sv =====
// Front end: accepts input items, decodes them into commands, queues those it keeps.
// Depends on lmfs_pkg.
module lmfs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  lmfs_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output lmfs_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import lmfs_pkg::*;

    localparam int CALC_W = WIDX_W + 2;

    t_cmd                w_cmd;
    logic                w_keep;
    logic                w_accept;
    logic                w_half;
    logic                w_over;
    logic [LINE_W-1:0]   w_row;
    logic [CALC_W-1:0]   w_idx;
    logic [6:0]          w_y;

    t_cmd                  r_q [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wp, n_wp;
    logic [CMDQ_PTR_W-1:0] r_rp, n_rp;
    logic [CMDQ_PTR_W:0]   r_cnt, n_cnt;

    // Split row into half and scan row
    always_comb begin
        w_y    = 7'(i_item.pixel_y);
        w_over = (w_y >= 7'(2 * SCAN_LINES));
        w_half = (w_y >= 7'(SCAN_LINES));
        if (w_half) begin
            w_row = LINE_W'(w_y - 7'(SCAN_LINES));
        end else begin
            w_row = LINE_W'(w_y);
        end
        w_idx = CALC_W'(1) + CALC_W'(WORDS_PER_LINE) * CALC_W'(w_row)
              - CALC_W'(w_half) + CALC_W'({i_item.color, 1'b0});
    end

    // Classify the item
    always_comb begin
        w_cmd.op       = OP_PIXEL;
        w_cmd.widx     = w_idx[WIDX_W-1:0];
        w_cmd.bit_pos  = {i_item.pixel_x[5:3], ~i_item.pixel_x[2:0]};
        w_cmd.pixel_on = i_item.pixel_on;
        w_keep         = 1'b0;
        unique case (i_item.func)
            FUNC_PIXEL: begin
                w_cmd.op = OP_PIXEL;
                w_keep   = (i_item.color <= COLOR_BLUE) && !w_over
                        && (w_idx < CALC_W'(FRAME_WORDS));
            end
            FUNC_CLEAR: begin
                w_cmd.op = OP_CLEAR;
                w_keep   = 1'b1;
            end
            FUNC_SCAN: begin
                w_cmd.op = OP_SCAN;
                w_keep   = 1'b1;
            end
            default: begin
                w_keep   = 1'b0;
            end
        endcase
    end

    assign full     = (r_cnt == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign w_accept = push && !full;

    // Advance queue pointers
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_accept && w_keep) begin
            n_wp  = r_wp + 1'b1;
            n_cnt = n_cnt + 1'b1;
        end
        if (i_cmd_pop && o_cmd_valid) begin
            n_rp  = r_rp + 1'b1;
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (w_accept && w_keep) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

endmodule

// ===== hdl/lmfs_back.sv =====
// Back end: runs commands against the frame store and queues result items.
// Depends on lmfs_pkg and lmfs_ram.
module lmfs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  lmfs_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic [7:0]          i_brightness,
    output logic                empty,
    input  logic                pop,
    output lmfs_pkg::t_out_item o_result
);
    import lmfs_pkg::*;

    t_bstate                r_state, n_state;
    logic [WCNT_W-1:0]      r_k, n_k;
    logic [LINE_W-1:0]      r_line, n_line;
    logic [WIDX_W-1:0]      r_base, n_base;
    t_cmd                   r_cmd, n_cmd;
    logic                   r_rd_pend;
    logic                   r_rd_vld;
    logic [FRAME_WORDS-1:0] r_valid;
    logic [7:0]             r_duty;
    logic [7:0]             r_dark;

    t_out_item              r_oq [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_oq_wp;
    logic [OUTQ_PTR_W-1:0]  r_oq_rp;
    logic [OUTQ_PTR_W:0]    r_oq_cnt;

    logic                   w_we;
    logic [WIDX_W-1:0]      w_raddr;
    logic [WORD_W-1:0]      w_rdata;
    logic [WORD_W-1:0]      w_word;
    logic [WORD_W-1:0]      w_mask;
    logic [WORD_W-1:0]      w_wdata;
    logic                   w_clr_all;
    logic                   w_room;
    logic                   w_oq_push;
    logic                   w_oq_pop;
    t_out_item              w_res;
    logic [DARK_PROD_W-1:0] w_dark_prod;

    lmfs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(FRAME_WORDS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_cmd.widx),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Derive latch timing from brightness
    assign w_dark_prod = DARK_PROD_W'(r_duty) * DARK_PROD_W'(DARK_MULT);

    always_ff @(posedge i_clk) begin
        r_duty <= 8'(DUTY_FULL) - i_brightness;
        r_dark <= w_dark_prod[DARK_SHIFT +: 8];
    end

    // Never-written words read as zero
    assign w_word  = r_rd_vld ? w_rdata : '0;
    assign w_mask  = WORD_W'(1) << r_cmd.bit_pos;
    assign w_wdata = r_cmd.pixel_on ? (w_word | w_mask) : (w_word & ~w_mask);
    assign w_room  = (r_oq_cnt <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH - WORDS_PER_LINE - 1));

    // Sequence commands
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_line    = r_line;
        n_base    = r_base;
        n_cmd     = r_cmd;
        o_cmd_pop = 1'b0;
        w_we      = 1'b0;
        w_clr_all = 1'b0;
        w_raddr   = r_base + WIDX_W'(r_k);
        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_PIXEL: begin
                            o_cmd_pop = 1'b1;
                            n_cmd     = i_cmd;
                            w_raddr   = i_cmd.widx;
                            n_state   = BS_PIX_WR;
                        end
                        OP_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            w_clr_all = 1'b1;
                        end
                        OP_SCAN: begin
                            if (w_room) begin
                                o_cmd_pop = 1'b1;
                                n_k       = '0;
                                n_state   = BS_SCAN;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_PIX_WR: begin
                w_we    = 1'b1;
                n_state = BS_IDLE;
            end
            BS_SCAN: begin
                if (r_k == WCNT_W'(WORDS_PER_LINE - 1)) begin
                    n_state = BS_TAIL;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            BS_TAIL: begin
                n_state = BS_LATCH;
            end
            BS_LATCH: begin
                if (r_line == LINE_W'(SCAN_LINES - 1)) begin
                    n_line = '0;
                    n_base = '0;
                end else begin
                    n_line = r_line + 1'b1;
                    n_base = r_base + WIDX_W'(WORDS_PER_LINE);
                end
                n_state = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_k       <= '0;
            r_line    <= '0;
            r_base    <= '0;
            r_rd_pend <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_line    <= n_line;
            r_base    <= n_base;
            r_rd_pend <= (r_state == BS_SCAN);
            r_rd_vld  <= r_valid[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // Track written words; drop all on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr_all) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[r_cmd.widx] <= 1'b1;
        end
    end

    // Build the result item
    always_comb begin
        w_res = '0;
        if (r_rd_pend) begin
            w_res.kind       = KIND_SHIFT;
            w_res.shift_word = w_word;
        end else begin
            w_res.kind         = KIND_LATCH;
            w_res.line_select  = 4'(r_line);
            w_res.dark_wait_us = r_dark;
            w_res.lit_wait_us  = 8'(WAIT_TOTAL_US) - r_dark;
            w_res.oe_duty      = r_duty;
            w_res.last         = 1'b1;
        end
    end

    assign w_oq_push = r_rd_pend || (r_state == BS_LATCH);
    assign w_oq_pop  = pop && !empty;

    // Result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (w_oq_push) begin
                r_oq_wp <= r_oq_wp + 1'b1;
            end
            if (w_oq_pop) begin
                r_oq_rp <= r_oq_rp + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + (OUTQ_PTR_W+1)'(w_oq_push)
                      - (OUTQ_PTR_W+1)'(w_oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oq_push) begin
            r_oq[r_oq_wp] <= w_res;
        end
    end

    assign empty    = (r_oq_cnt == '0);
    assign o_result = r_oq[r_oq_rp];

endmodule

// ===== hdl/led_matrix_frame_scan_top.sv =====
// Top level of the LED matrix frame scan block: brightness register,
// front end and back end. Depends on lmfs_pkg, lmfs_front and lmfs_back.
//
// Frame store and line scan sequencer for a 64x32 RGB panel with 1/16 scan.
// Items enter through a four-entry command queue. In the back end a pixel
// write reads the frame RAM when it is taken, then modifies and writes it in
// the pixel write state. A scan makes six reads on the single RAM read port,
// then passes a tail state for the last read data and a latch state for the
// latch item. A scan starts only when the eight-entry result queue has room
// for all seven of its result items. The store is cleared at reset and by a
// clear item at once through per-word valid bits, so there is no clearing pass.
// A brightness write reaches the latch timing via r_brightness, r_duty, r_dark.
module led_matrix_frame_scan_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  lmfs_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output lmfs_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata
);
    import lmfs_pkg::*;

    logic [7:0] r_brightness;
    logic       w_cmd_valid;
    logic       w_cmd_pop;
    t_cmd       w_cmd;

    // Hold the brightness setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHT_RESET;
        end else if (i_cfg_we) begin
            r_brightness <= i_cfg_wdata;
        end
    end

    lmfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    lmfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_brightness(r_brightness),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule
